/* hw/rtl/window_vibration_position_monitor_assert.svh */
// assertion macros used by the checker file
`ifndef WINDOW_VIBRATION_POSITION_MONITOR_ASSERT_SVH
`define WINDOW_VIBRATION_POSITION_MONITOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WVPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define WVPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wvpm_pkg.sv */
package wvpm_pkg;

    localparam int NUM_AXES   = 3;
    localparam int AVG_W      = 10;
    localparam int PEAK_W     = 8;
    localparam int NORM_W     = 10;
    localparam int DEV_W      = 8;
    localparam int ENA_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int NUM_MON    = 5;
    localparam int ACTIVE_BIT = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [6:0]       PCT_SCALE = 7'd100;
    localparam logic [DEV_W-1:0] PCT_MAX   = 8'd255;

    // monitor slots in the fired vector
    localparam int MON_DELTA  = 0;
    localparam int MON_PEAK_A = 1;
    localparam int MON_POS    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIB_DELTA_LIMIT  = 3'd0,
        CFG_PEAK_LIMIT_A     = 3'd1,
        CFG_PEAK_LIMIT_B     = 3'd2,
        CFG_PEAK_LIMIT_C     = 3'd3,
        CFG_ACTION_ENABLES   = 3'd4,
        CFG_AXIS_NORMALS     = 3'd5,
        CFG_DEVIATION_LIMITS = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [AVG_W-1:0]                   vib_delta_limit;
        logic [NUM_AXES-1:0][PEAK_W-1:0]    peak_limit;
        logic [ENA_W-1:0]                   action_enables;
        logic [NUM_AXES-1:0][NORM_W-1:0]    axis_normals;
        logic [NUM_AXES-1:0][DEV_W-1:0]     deviation_limits;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        vib_delta_limit:  10'h3FF,
        peak_limit:       {NUM_AXES{8'hFF}},
        action_enables:   '0,
        axis_normals:     '0,
        deviation_limits: '0
    };

endpackage

/* hw/rtl/wvpm_front.sv */
module wvpm_front #(
    parameter int WINDOW_SAMPLES = 16,
    parameter int ADC_BITS       = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ADC_BITS-1:0] i_x_sample,
    input  logic [ADC_BITS-1:0] i_y_sample,
    input  logic [ADC_BITS-1:0] i_z_sample,
    input  logic [ADC_BITS-1:0] i_vib_a_sample,
    input  logic [ADC_BITS-1:0] i_vib_b_sample,
    input  logic [ADC_BITS-1:0] i_vib_c_sample,
    input  logic                i_full,
    output logic                o_push,
    output logic [wvpm_pkg::NUM_AXES*(ADC_BITS+$clog2(WINDOW_SAMPLES)+wvpm_pkg::PEAK_W)-1:0]
                                o_rec
);
    import wvpm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_SAMPLES);
    localparam int SUM_W = ADC_BITS + CNT_W;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW_SAMPLES - 1);

    logic [CNT_W-1:0]                     r_count;
    logic [NUM_AXES-1:0][SUM_W-1:0]       r_sum, n_sum;
    logic [NUM_AXES-1:0][ADC_BITS-1:0]    r_peak, n_peak;
    logic [NUM_AXES-1:0][ADC_BITS-1:0]    axis_in, vib_in;
    logic                                 last, accept;

    assign axis_in = {i_z_sample, i_y_sample, i_x_sample};
    assign vib_in  = {i_vib_c_sample, i_vib_b_sample, i_vib_a_sample};

    assign last       = (r_count == LAST_COUNT);
    // only the closing beat of a window needs room in the queue
    assign o_in_ready = !i_full || !last;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && last;

    always_comb begin
        o_rec = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            n_sum[i]  = r_sum[i] + SUM_W'(axis_in[i]);
            n_peak[i] = (vib_in[i] > r_peak[i]) ? vib_in[i] : r_peak[i];
            o_rec[i*SUM_W +: SUM_W] = n_sum[i];
            o_rec[NUM_AXES*SUM_W + i*PEAK_W +: PEAK_W] = n_peak[i][ADC_BITS-1 -: PEAK_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_peak  <= '0;
        end else if (accept) begin
            if (last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_peak  <= '0;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum   <= n_sum;
                r_peak  <= n_peak;
            end
        end
    end

endmodule

/* hw/rtl/wvpm_queue.sv */
module wvpm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/wvpm_back.sv */
module wvpm_back #(
    parameter int WINDOW_SAMPLES = 16,
    parameter int ADC_BITS       = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wvpm_pkg::t_cfg        i_cfg,
    input  logic                  i_empty,
    input  logic [wvpm_pkg::NUM_AXES*(ADC_BITS+$clog2(WINDOW_SAMPLES)+wvpm_pkg::PEAK_W)-1:0]
                                  i_rec,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [wvpm_pkg::AVG_W-1:0]  o_x_average,
    output logic [wvpm_pkg::AVG_W-1:0]  o_y_average,
    output logic [wvpm_pkg::AVG_W-1:0]  o_z_average,
    output logic [wvpm_pkg::AVG_W-1:0]  o_axis_change,
    output logic [wvpm_pkg::PEAK_W-1:0] o_peak_a,
    output logic [wvpm_pkg::PEAK_W-1:0] o_peak_b,
    output logic [wvpm_pkg::PEAK_W-1:0] o_peak_c,
    output logic                  o_beep_request,
    output logic                  o_shutdown_request,
    output logic                  o_position_alarm
);
    import wvpm_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_SAMPLES);
    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int SHIFT  = SUM_W + CNT_W;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int DW     = (ADC_BITS > AVG_W) ? ADC_BITS : AVG_W;
    localparam int PW     = DW + DEV_W + 1;
    // rounded-up reciprocal: exact quotient for every SUM_W-bit sum
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(RECIP_L);

    logic en;

    logic [NUM_AXES-1:0][SUM_W-1:0]  rec_sum;
    logic [NUM_AXES-1:0][PEAK_W-1:0] rec_peak;

    // stage 1: reciprocal products
    logic                            r_s1_valid;
    logic [NUM_AXES-1:0][PROD_W-1:0] r_s1_prod, n_s1_prod;
    logic [NUM_AXES-1:0][PEAK_W-1:0] r_s1_peak;

    // stage 2: means and distances
    logic                              r_s2_valid, r_s2_first;
    logic [NUM_AXES-1:0][ADC_BITS-1:0] r_s2_mean, n_mean;
    logic [NUM_AXES-1:0][DW-1:0]       r_s2_diff, n_diff, r_s2_dev, n_dev;
    logic [NUM_AXES-1:0][PEAK_W-1:0]   r_s2_peak;
    logic [NUM_AXES-1:0][AVG_W-1:0]    r_prev;
    logic                              r_prev_valid;

    // stage 3: change, threshold products
    logic                              r_s3_valid, r_s3_delta_fire, n_delta_fire;
    logic [NUM_AXES-1:0][ADC_BITS-1:0] r_s3_mean;
    logic [AVG_W-1:0]                  r_s3_change, n_s3_change, change_m;
    logic [AVG_W-1:0]                  r_held;
    logic [DW-1:0]                     max01, max012;
    logic [NUM_AXES-1:0][PW-1:0]       r_s3_num, n_num, r_s3_den, n_den;
    logic [NUM_AXES-1:0]               r_s3_mean_zero, n_mean_zero;
    logic [NUM_AXES-1:0]               r_s3_dev_nz, n_dev_nz;
    logic [NUM_AXES-1:0]               r_s3_lim_max, n_lim_max;
    logic [NUM_AXES-1:0]               r_s3_peak_fire, n_peak_fire;
    logic [NUM_AXES-1:0][PEAK_W-1:0]   r_s3_peak;

    // output register
    logic                              r_out_valid;
    logic [NUM_AXES-1:0][AVG_W-1:0]    r_out_avg;
    logic [AVG_W-1:0]                  r_out_change;
    logic [NUM_AXES-1:0][PEAK_W-1:0]   r_out_peak;
    logic                              r_out_beep, r_out_shut, r_out_pos;
    logic [NUM_AXES-1:0]               axis_fire;
    logic                              pos_alarm, n_beep, n_shut;
    logic [NUM_MON-1:0]                fired;

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            rec_sum[i]   = i_rec[i*SUM_W +: SUM_W];
            rec_peak[i]  = i_rec[NUM_AXES*SUM_W + i*PEAK_W +: PEAK_W];
            n_s1_prod[i] = PROD_W'(rec_sum[i]) * PROD_W'(RECIP);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n_mean[i] = r_s1_prod[i][SHIFT +: ADC_BITS];
            n_diff[i] = (DW'(n_mean[i]) > DW'(r_prev[i])) ?
                        DW'(n_mean[i]) - DW'(r_prev[i]) : DW'(r_prev[i]) - DW'(n_mean[i]);
            n_dev[i]  = (DW'(n_mean[i]) > DW'(i_cfg.axis_normals[i])) ?
                        DW'(n_mean[i]) - DW'(i_cfg.axis_normals[i]) :
                        DW'(i_cfg.axis_normals[i]) - DW'(n_mean[i]);
        end
    end

    always_comb begin
        max01    = (r_s2_diff[1] > r_s2_diff[0]) ? r_s2_diff[1] : r_s2_diff[0];
        max012   = (r_s2_diff[2] > max01) ? r_s2_diff[2] : max01;
        change_m = AVG_W'(max012);
        // first window repeats the held value and never trips the delta monitor
        n_s3_change  = r_s2_first ? r_held : change_m;
        n_delta_fire = !r_s2_first && (change_m > i_cfg.vib_delta_limit);
        for (int i = 0; i < NUM_AXES; i++) begin
            // pct > lim  <=>  d*100 >= (lim+1)*mean, unless lim is at saturation
            n_num[i]       = PW'(r_s2_dev[i]) * PW'(PCT_SCALE);
            n_den[i]       = PW'({1'b0, i_cfg.deviation_limits[i]} + 9'd1) * PW'(r_s2_mean[i]);
            n_mean_zero[i] = (r_s2_mean[i] == '0);
            n_dev_nz[i]    = (r_s2_dev[i] != '0);
            n_lim_max[i]   = (i_cfg.deviation_limits[i] == PCT_MAX);
            n_peak_fire[i] = (r_s2_peak[i] > i_cfg.peak_limit[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            axis_fire[i] = r_s3_mean_zero[i] ? r_s3_dev_nz[i] :
                           (!r_s3_lim_max[i] && (r_s3_num[i] >= r_s3_den[i]));
        end
        pos_alarm = i_cfg.action_enables[ACTIVE_BIT] && (i_cfg.deviation_limits != '0)
                    && (|axis_fire);
        fired[MON_DELTA]                   = r_s3_delta_fire;
        fired[MON_PEAK_A +: NUM_AXES]      = r_s3_peak_fire;
        fired[MON_POS]                     = pos_alarm;
        n_beep = 1'b0;
        n_shut = 1'b0;
        for (int m = 0; m < NUM_MON; m++) begin
            n_beep = n_beep | (fired[m] & i_cfg.action_enables[2*m]);
            n_shut = n_shut | (fired[m] & i_cfg.action_enables[2*m+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_held       <= '0;
        end else if (en) begin
            r_s1_valid  <= !i_empty;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            if (r_s1_valid) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_prev[i] <= AVG_W'(n_mean[i]);
                end
                r_prev_valid <= 1'b1;
            end
            if (r_s2_valid) begin
                r_held <= n_s3_change;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_prod       <= n_s1_prod;
            r_s1_peak       <= rec_peak;
            r_s2_mean       <= n_mean;
            r_s2_diff       <= n_diff;
            r_s2_dev        <= n_dev;
            r_s2_peak       <= r_s1_peak;
            r_s2_first      <= !r_prev_valid;
            r_s3_mean       <= r_s2_mean;
            r_s3_change     <= n_s3_change;
            r_s3_delta_fire <= n_delta_fire;
            r_s3_num        <= n_num;
            r_s3_den        <= n_den;
            r_s3_mean_zero  <= n_mean_zero;
            r_s3_dev_nz     <= n_dev_nz;
            r_s3_lim_max    <= n_lim_max;
            r_s3_peak_fire  <= n_peak_fire;
            r_s3_peak       <= r_s2_peak;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_out_avg[i] <= AVG_W'(r_s3_mean[i]);
            end
            r_out_change <= r_s3_change;
            r_out_peak   <= r_s3_peak;
            r_out_beep   <= n_beep;
            r_out_shut   <= n_shut;
            r_out_pos    <= pos_alarm;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_x_average        = r_out_avg[0];
    assign o_y_average        = r_out_avg[1];
    assign o_z_average        = r_out_avg[2];
    assign o_axis_change      = r_out_change;
    assign o_peak_a           = r_out_peak[0];
    assign o_peak_b           = r_out_peak[1];
    assign o_peak_c           = r_out_peak[2];
    assign o_beep_request     = r_out_beep;
    assign o_shutdown_request = r_out_shut;
    assign o_position_alarm   = r_out_pos;

endmodule

/* hw/rtl/window_vibration_position_monitor.sv */
// a window result passes the queue, then stage 1, stage 2, stage 3 and the output register
// throughput: one sample beat per cycle while the queue can take a closing beat, one result per WINDOW_SAMPLES beats
// the front accumulates each accepted beat; the back is a 4-stage pipeline fed by a 4-deep queue
// reset: synchronous, active low; clears sums, peaks, history and restores register defaults
module window_vibration_position_monitor #(
    parameter int WINDOW_SAMPLES = 16,
    parameter int ADC_BITS       = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wvpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wvpm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ADC_BITS-1:0]                i_x_sample,
    input  logic [ADC_BITS-1:0]                i_y_sample,
    input  logic [ADC_BITS-1:0]                i_z_sample,
    input  logic [ADC_BITS-1:0]                i_vib_a_sample,
    input  logic [ADC_BITS-1:0]                i_vib_b_sample,
    input  logic [ADC_BITS-1:0]                i_vib_c_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [wvpm_pkg::AVG_W-1:0]         o_x_average,
    output logic [wvpm_pkg::AVG_W-1:0]         o_y_average,
    output logic [wvpm_pkg::AVG_W-1:0]         o_z_average,
    output logic [wvpm_pkg::AVG_W-1:0]         o_axis_change,
    output logic [wvpm_pkg::PEAK_W-1:0]        o_peak_a,
    output logic [wvpm_pkg::PEAK_W-1:0]        o_peak_b,
    output logic [wvpm_pkg::PEAK_W-1:0]        o_peak_c,
    output logic                               o_beep_request,
    output logic                               o_shutdown_request,
    output logic                               o_position_alarm
);
    import wvpm_pkg::*;

    localparam int REC_W = NUM_AXES * (ADC_BITS + $clog2(WINDOW_SAMPLES) + PEAK_W);

    t_cfg             r_cfg;
    logic             q_push, q_full, q_pop, q_empty;
    logic [REC_W-1:0] q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_VIB_DELTA_LIMIT:  r_cfg.vib_delta_limit  <= i_cfg_data[AVG_W-1:0];
                CFG_PEAK_LIMIT_A:     r_cfg.peak_limit[0]    <= i_cfg_data[PEAK_W-1:0];
                CFG_PEAK_LIMIT_B:     r_cfg.peak_limit[1]    <= i_cfg_data[PEAK_W-1:0];
                CFG_PEAK_LIMIT_C:     r_cfg.peak_limit[2]    <= i_cfg_data[PEAK_W-1:0];
                CFG_ACTION_ENABLES:   r_cfg.action_enables   <= i_cfg_data[ENA_W-1:0];
                CFG_AXIS_NORMALS:     r_cfg.axis_normals     <= i_cfg_data[NUM_AXES*NORM_W-1:0];
                CFG_DEVIATION_LIMITS: r_cfg.deviation_limits <= i_cfg_data[NUM_AXES*DEV_W-1:0];
                default: ;
            endcase
        end
    end

    wvpm_front #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .ADC_BITS       (ADC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_z_sample     (i_z_sample),
        .i_vib_a_sample (i_vib_a_sample),
        .i_vib_b_sample (i_vib_b_sample),
        .i_vib_c_sample (i_vib_c_sample),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_rec          (q_wdata)
    );

    wvpm_queue #(
        .DATA_W (REC_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    wvpm_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .ADC_BITS       (ADC_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_empty            (q_empty),
        .i_rec              (q_rdata),
        .o_pop              (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_x_average        (o_x_average),
        .o_y_average        (o_y_average),
        .o_z_average        (o_z_average),
        .o_axis_change      (o_axis_change),
        .o_peak_a           (o_peak_a),
        .o_peak_b           (o_peak_b),
        .o_peak_c           (o_peak_c),
        .o_beep_request     (o_beep_request),
        .o_shutdown_request (o_shutdown_request),
        .o_position_alarm   (o_position_alarm)
    );

endmodule

/* hw/rtl/wvpm_checker.sv */
`include "window_vibration_position_monitor_assert.svh"

module wvpm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [wvpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [wvpm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [wvpm_pkg::AVG_W-1:0]      o_x_average,
    input logic [wvpm_pkg::AVG_W-1:0]      o_y_average,
    input logic [wvpm_pkg::AVG_W-1:0]      o_z_average,
    input logic [wvpm_pkg::AVG_W-1:0]      o_axis_change,
    input logic [wvpm_pkg::PEAK_W-1:0]     o_peak_a,
    input logic [wvpm_pkg::PEAK_W-1:0]     o_peak_b,
    input logic [wvpm_pkg::PEAK_W-1:0]     o_peak_c,
    input logic                            o_beep_request,
    input logic                            o_shutdown_request,
    input logic                            o_position_alarm
);
    import wvpm_pkg::*;

    // shadow of the register bits that gate the alarm and beep outputs
    logic r_pos_active, r_dev_nonzero, r_beep_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_active  <= 1'b0;
            r_dev_nonzero <= 1'b0;
            r_beep_any    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ACTION_ENABLES: begin
                    r_pos_active <= i_cfg_data[ACTIVE_BIT];
                    r_beep_any   <= i_cfg_data[0] | i_cfg_data[2] | i_cfg_data[4]
                                    | i_cfg_data[6] | i_cfg_data[8];
                end
                CFG_DEVIATION_LIMITS: begin
                    r_dev_nonzero <= (i_cfg_data[NUM_AXES*DEV_W-1:0] != '0);
                end
                default: ;
            endcase
        end
    end

    `WVPM_ASSERT_NEXT(a_valid_hold, o_out_valid && !i_out_ready, o_out_valid,
        "result beat dropped while stalled")
    `WVPM_ASSERT_NEXT(a_payload_hold, o_out_valid && !i_out_ready,
        $stable(o_x_average) && $stable(o_y_average) && $stable(o_z_average)
        && $stable(o_axis_change) && $stable(o_peak_a) && $stable(o_peak_b)
        && $stable(o_peak_c) && $stable(o_beep_request)
        && $stable(o_shutdown_request) && $stable(o_position_alarm),
        "result payload changed while stalled")
    `WVPM_ASSERT_SAME(a_reset_idle, $rose(i_rst_n), !o_out_valid,
        "result valid right after reset")
    `WVPM_ASSERT_SAME(a_pos_gated, o_out_valid && !(r_pos_active && r_dev_nonzero),
        !o_position_alarm, "position alarm while position test inactive")
    `WVPM_ASSERT_SAME(a_beep_gated, o_out_valid && !r_beep_any, !o_beep_request,
        "beep request with all beep enables clear")

endmodule

bind window_vibration_position_monitor wvpm_checker u_wvpm_checker (.*);
